[rtl/dlm_pkg.sv]
// Package with the types, constants and register codes of the level monitor.
package dlm_pkg;

    localparam int CHANNELS = 3;
    localparam int CNT_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD = 1'd1;

    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 16'd5;
    localparam logic [CNT_W-1:0] PERIOD_RESET = 16'd1;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_SECONDS = 1'b1;

    typedef struct packed {
        logic cmd;
        logic level_a;
        logic level_b;
        logic level_c;
    } in_word_t;

    typedef struct packed {
        logic stable_a;
        logic stable_b;
        logic stable_c;
        logic lamp_all_ok;
        logic lamp_a;
        logic lamp_b;
        logic lamp_c;
        logic report_due;
    } out_word_t;

    // Control that the top level hands to the state modules for one word.
    typedef struct packed {
        logic fire;
        logic cmd;
    } step_ctl_t;

endpackage

[rtl/dlm_chan.sv]
// Debounce state and next-state logic for one level switch channel.
module dlm_chan
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dlm_pkg::step_ctl_t          ctl,
    input  logic                        pin,
    input  logic [dlm_pkg::CNT_W-1:0]   debounce_ticks,
    output logic                        stable_next
);

    logic                       raw_reg;
    logic                       raw_next;
    logic                       stable_reg;
    logic                       pending_reg;
    logic                       pending_next;
    logic [dlm_pkg::CNT_W-1:0]  count_reg;
    logic [dlm_pkg::CNT_W-1:0]  count_next;
    logic                       changed;
    logic [dlm_pkg::CNT_W-1:0]  count_inc;
    logic                       scan;

    assign scan = ctl.fire && (ctl.cmd == dlm_pkg::CMD_SCAN);
    assign changed = raw_reg != pin;
    // A change restarts the settle count from zero before this tick counts.
    assign count_inc = (changed ? '0 : count_reg) + dlm_pkg::CNT_W'(1);

    always_comb
    begin
        raw_next = raw_reg;
        pending_next = pending_reg;
        count_next = count_reg;
        stable_next = stable_reg;
        if (scan)
        begin
            raw_next = pin;
            if (changed || pending_reg)
            begin
                if (count_inc == debounce_ticks)
                begin
                    pending_next = 1'b0;
                    stable_next = pin;
                    count_next = '0;
                end
                else
                begin
                    pending_next = 1'b1;
                    count_next = count_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg <= 1'b0;
            stable_reg <= 1'b1;
            pending_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            raw_reg <= raw_next;
            stable_reg <= stable_next;
            pending_reg <= pending_next;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/dlm_report.sv]
// Seconds counter that flags a status report once the period is reached.
module dlm_report
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dlm_pkg::step_ctl_t          ctl,
    input  logic [dlm_pkg::CNT_W-1:0]   report_period,
    output logic                        report_due
);

    logic [dlm_pkg::CNT_W-1:0]  seconds_reg;
    logic [dlm_pkg::CNT_W-1:0]  seconds_next;
    logic [dlm_pkg::CNT_W-1:0]  seconds_inc;

    assign seconds_inc = (ctl.cmd == dlm_pkg::CMD_SECONDS)
                         ? seconds_reg + dlm_pkg::CNT_W'(1) : seconds_reg;
    // The check runs on every word, so a scan tick can also send a report.
    assign report_due = ctl.fire && (seconds_inc >= report_period);

    always_comb
    begin
        seconds_next = seconds_reg;
        if (ctl.fire)
        begin
            seconds_next = report_due ? '0 : seconds_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seconds_reg <= '0;
        end
        else
        begin
            seconds_reg <= seconds_next;
        end
    end

endmodule

[rtl/debounced_level_monitor_unit.sv]
// Top level of the three-channel debounced level monitor with status report.
//
//   channel   direction   word         handshake
//   in        input       in_word      in_valid / in_stall
//   out       output      out_word     out_valid / out_stall
//   cfg       input       cfg_data     cfg_wr_en, cfg_index (no handshake)
//
// Each word passes from acceptance into the input register, then through the channel
// and report update into the result register.
// A new word is accepted every cycle while the output is not stalled.
// Reset puts raw levels at 0 and stable levels at 1, and restores the registers.
// A stalled result holds the input register, which then raises in_stall.
module debounced_level_monitor_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  dlm_pkg::in_word_t                   in_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output dlm_pkg::out_word_t                  out_word,
    input  logic                                cfg_wr_en,
    input  logic [dlm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dlm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [dlm_pkg::CNT_W-1:0]      debounce_reg;
    logic [dlm_pkg::CNT_W-1:0]      period_reg;
    logic                           in_valid_reg;
    dlm_pkg::in_word_t              in_word_reg;
    logic                           out_valid_reg;
    dlm_pkg::out_word_t             out_word_reg;
    dlm_pkg::out_word_t             out_word_next;
    logic                           out_free;
    dlm_pkg::step_ctl_t             ctl;
    logic [dlm_pkg::CHANNELS-1:0]   pins;
    logic [dlm_pkg::CHANNELS-1:0]   stable;
    logic                           report_due;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= dlm_pkg::DEBOUNCE_RESET;
            period_reg <= dlm_pkg::PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                dlm_pkg::REG_DEBOUNCE_TICKS: debounce_reg <= cfg_data;
                dlm_pkg::REG_REPORT_PERIOD:  period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !out_free;
    assign ctl.fire = in_valid_reg && out_free;
    assign ctl.cmd = in_word_reg.cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_word_reg <= in_word;
        end
    end

    // Channel A is bit 0.
    assign pins = {in_word_reg.level_c, in_word_reg.level_b, in_word_reg.level_a};

    for (genvar g = 0; g < dlm_pkg::CHANNELS; g++)
    begin : g_chan
        dlm_chan u_chan
        (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctl            (ctl),
            .pin            (pins[g]),
            .debounce_ticks (debounce_reg),
            .stable_next    (stable[g])
        );
    end

    dlm_report u_report
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .report_period  (period_reg),
        .report_due     (report_due)
    );

    always_comb
    begin
        out_word_next.stable_a = stable[0];
        out_word_next.stable_b = stable[1];
        out_word_next.stable_c = stable[2];
        out_word_next.lamp_all_ok = &stable;
        out_word_next.lamp_a = !stable[0];
        out_word_next.lamp_b = !stable[1];
        out_word_next.lamp_c = !stable[2];
        out_word_next.report_due = report_due;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= ctl.fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word = out_word_reg;

`ifndef SYNTHESIS
    a_lamps_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.lamp_all_ok ==
                       (out_word.stable_a && out_word.stable_b && out_word.stable_c))
                      && (out_word.lamp_a != out_word.stable_a)
                      && (out_word.lamp_b != out_word.stable_b)
                      && (out_word.lamp_c != out_word.stable_c))
        else $error("lamp outputs disagree with stable levels");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled while the pipeline has room");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire |=> out_valid)
        else $error("processed word produced no result");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> !$past(ctl.fire))
        else $error("result register overwritten while stalled");
`endif

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the debounced three-channel level monitor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 11;
    localparam int PIPE_CYCLES = 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASES = 6;
    localparam int PHASE_WORDS = 285;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    dlm_pkg::in_word_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    dlm_pkg::out_word_t out_word;
    logic cfg_wr_en = 1'b0;
    logic [dlm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dlm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Copy of the monitor state, at its reset values.
    logic [dlm_pkg::CNT_W-1:0] debounce_cfg = dlm_pkg::DEBOUNCE_RESET;
    logic [dlm_pkg::CNT_W-1:0] period_cfg = dlm_pkg::PERIOD_RESET;
    logic [dlm_pkg::CHANNELS-1:0] raw_lvl = '0;
    logic [dlm_pkg::CHANNELS-1:0] stable_lvl = '1;
    logic [dlm_pkg::CHANNELS-1:0] pending = '0;
    logic [dlm_pkg::CNT_W-1:0] settle_cnt [dlm_pkg::CHANNELS] = '{default: '0};
    logic [dlm_pkg::CNT_W-1:0] seconds_cnt = '0;

    dlm_pkg::out_word_t expected_status [$];
    int errors = 0;
    int reports = 0;
    int result_no = 0;
    bit in_gaps_on = 1'b1;
    bit out_stalls_on = 1'b1;

    debounced_level_monitor_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Channel 0 is A, 1 is B, 2 is C.
    function automatic dlm_pkg::out_word_t predict_status(input dlm_pkg::in_word_t w);
        logic [dlm_pkg::CHANNELS-1:0] pins;
        dlm_pkg::out_word_t r;
        pins = {w.level_c, w.level_b, w.level_a};
        if (w.cmd == dlm_pkg::CMD_SCAN)
        begin
            for (int ch = 0; ch < dlm_pkg::CHANNELS; ch++)
            begin
                if (raw_lvl[ch] != pins[ch])
                begin
                    raw_lvl[ch] = pins[ch];
                    settle_cnt[ch] = '0;
                    pending[ch] = 1'b1;
                end
                if (pending[ch])
                begin
                    settle_cnt[ch] = settle_cnt[ch] + 1'b1;
                    if (settle_cnt[ch] == debounce_cfg)
                    begin
                        pending[ch] = 1'b0;
                        stable_lvl[ch] = raw_lvl[ch];
                        settle_cnt[ch] = '0;
                    end
                end
            end
        end
        else
        begin
            seconds_cnt = seconds_cnt + 1'b1;
        end
        r.report_due = 1'b0;
        if (seconds_cnt >= period_cfg)
        begin
            r.report_due = 1'b1;
            seconds_cnt = '0;
        end
        r.stable_a = stable_lvl[0];
        r.stable_b = stable_lvl[1];
        r.stable_c = stable_lvl[2];
        r.lamp_all_ok = &stable_lvl;
        r.lamp_a = ~stable_lvl[0];
        r.lamp_b = ~stable_lvl[1];
        r.lamp_c = ~stable_lvl[2];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!in_gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input dlm_pkg::in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_word <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_status.push_back(predict_status(w));
        @(negedge clk);
    endtask

    task automatic send_scan(input logic a, input logic b, input logic c, input int count);
        dlm_pkg::in_word_t w;
        w.cmd = dlm_pkg::CMD_SCAN;
        w.level_a = a;
        w.level_b = b;
        w.level_c = c;
        repeat (count) send_word(w);
    endtask

    task automatic send_seconds(input logic [2:0] levels);
        dlm_pkg::in_word_t w;
        w = dlm_pkg::in_word_t'({1'b0, levels});
        w.cmd = dlm_pkg::CMD_SECONDS;
        send_word(w);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(negedge clk);
        repeat (PIPE_CYCLES + 2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [dlm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dlm_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == dlm_pkg::REG_DEBOUNCE_TICKS)
            debounce_cfg = val;
        else
            period_cfg = val;
    endtask

    // Reset values: raw levels at 0 and stable levels at 1, debounce 5, period 1.
    task automatic test_power_up();
        send_seconds(3'b111);
        send_scan(1'b0, 1'b0, 1'b0, 2);
        send_scan(1'b1, 1'b1, 1'b1, 5);
        send_scan(1'b0, 1'b0, 1'b0, 4);
        send_scan(1'b1, 1'b1, 1'b1, 1);
        send_scan(1'b0, 1'b1, 1'b1, 5);
        send_seconds(3'b010);
        send_scan(1'b0, 1'b0, 1'b0, 5);
    endtask

    // One-scan debounce and a zero period, which reports on every word, then a period of two.
    task automatic test_register_edges();
        wait_idle();
        write_reg(dlm_pkg::REG_DEBOUNCE_TICKS, 16'd1);
        write_reg(dlm_pkg::REG_REPORT_PERIOD, 16'd0);
        send_scan(1'b1, 1'b1, 1'b1, 1);
        send_scan(1'b0, 1'b1, 1'b0, 1);
        send_seconds(3'b101);
        send_scan(1'b1, 1'b0, 1'b1, 1);
        wait_idle();
        write_reg(dlm_pkg::REG_REPORT_PERIOD, 16'd2);
        send_seconds(3'b000);
        send_seconds(3'b111);
        send_scan(1'b0, 1'b0, 1'b0, 1);
        send_seconds(3'b011);
    endtask

    // Debounce counts changed while a channel is still settling.
    task automatic test_debounce_change();
        wait_idle();
        in_gaps_on = 1'b0;
        out_stalls_on = 1'b0;
        write_reg(dlm_pkg::REG_DEBOUNCE_TICKS, 16'd10);
        write_reg(dlm_pkg::REG_REPORT_PERIOD, 16'd1);
        send_scan(~raw_lvl[0], raw_lvl[1], raw_lvl[2], 4);
        wait_idle();
        // The debounce count drops below the running count of channel A,
        // so no match comes until the counter wraps.
        write_reg(dlm_pkg::REG_DEBOUNCE_TICKS, 16'd2);
        send_scan(raw_lvl[0], raw_lvl[1], raw_lvl[2], 20);
        wait_idle();
        // Raised above the running count again, it settles a few scans later.
        write_reg(dlm_pkg::REG_DEBOUNCE_TICKS, 16'd30);
        send_scan(raw_lvl[0], raw_lvl[1], raw_lvl[2], 8);
        wait_idle();
        write_reg(dlm_pkg::REG_DEBOUNCE_TICKS, 16'd0);
        send_scan(raw_lvl[0], ~raw_lvl[1], raw_lvl[2], 20);
        in_gaps_on = 1'b1;
        out_stalls_on = 1'b1;
    endtask

    // Levels held for runs around the debounce count, with bounces and noise.
    task automatic test_random_traffic();
        logic [dlm_pkg::CHANNELS-1:0] target;
        logic [dlm_pkg::CHANNELS-1:0] pins;
        int hold [dlm_pkg::CHANNELS];
        int base;
        int r;
        logic [dlm_pkg::CNT_W-1:0] deb;
        logic [dlm_pkg::CNT_W-1:0] per;
        dlm_pkg::in_word_t w;
        target = raw_lvl;
        hold = '{default: 0};
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            unique case (p)
                0:
                begin
                    deb = 16'd1;
                    per = 16'hFFFF;
                end
                1:
                begin
                    deb = 16'hFFFF;
                    per = 16'd1;
                end
                default:
                begin
                    deb = dlm_pkg::CNT_W'($urandom_range(1, 8));
                    per = dlm_pkg::CNT_W'($urandom_range(1, 6));
                end
            endcase
            write_reg(dlm_pkg::REG_DEBOUNCE_TICKS, deb);
            write_reg(dlm_pkg::REG_REPORT_PERIOD, per);
            in_gaps_on = (p != 2) && (p != 4);
            out_stalls_on = (p != 2);
            base = (deb > 8) ? 8 : int'(deb);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                begin
                    w = dlm_pkg::in_word_t'($urandom_range(0, 7));
                    w.cmd = dlm_pkg::CMD_SECONDS;
                end
                else if (r < 20)
                begin
                    w = dlm_pkg::in_word_t'($urandom_range(0, 15));
                end
                else
                begin
                    for (int ch = 0; ch < dlm_pkg::CHANNELS; ch++)
                    begin
                        if (hold[ch] == 0)
                        begin
                            if ($urandom_range(0, 9) < 6)
                                target[ch] = ~target[ch];
                            hold[ch] = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 2)
                                                                  : base + $urandom_range(0, 6);
                        end
                        hold[ch]--;
                        pins[ch] = target[ch] ^ ($urandom_range(0, 99) < 8);
                    end
                    w.cmd = dlm_pkg::CMD_SCAN;
                    w.level_a = pins[0];
                    w.level_b = pins[1];
                    w.level_c = pins[2];
                end
                send_word(w);
            end
        end
        in_gaps_on = 1'b1;
        out_stalls_on = 1'b1;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_power_up();
        test_register_edges();
        test_debounce_change();
        test_random_traffic();
        wait_idle();
        repeat (PIPE_CYCLES + 2) @(negedge clk);
        if (expected_status.size() != 0)
            errors++;
        if (errors == 0)
            $display("[debounced_level_monitor_unit] OK");
        else
            $display("[debounced_level_monitor_unit] ERROR");
        $finish;
    end

    // Receiver back-pressure: mostly short stalls, now and then a long one.
    initial
    begin : stall_driver
        int r;
        forever
        begin
            @(negedge clk);
            if (out_stalls_on && $urandom_range(0, 99) < 25)
            begin
                r = $urandom_range(0, 99);
                out_stall <= 1'b1;
                if (r < 60)
                    repeat ($urandom_range(1, 2)) @(negedge clk);
                else if (r < 92)
                    repeat ($urandom_range(3, 8)) @(negedge clk);
                else
                    repeat ($urandom_range(20, 40)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        dlm_pkg::out_word_t want;
        logic [$bits(dlm_pkg::out_word_t)-1:0] diff;
        if (rst_n && out_valid && !out_stall)
        begin
            result_no++;
            if (expected_status.size() == 0)
            begin
                errors++;
                reports++;
                if (reports <= MAX_REPORTS)
                    $display("result %0d arrived with no word expected: got %b",
                             result_no, out_word);
            end
            else
            begin
                want = expected_status.pop_front();
                for (int i = 0; i < $bits(dlm_pkg::out_word_t); i++)
                    diff[i] = (out_word[i] !== want[i]);
                if (diff != '0)
                begin
                    errors++;
                    reports++;
                    if (reports <= MAX_REPORTS)
                        $display({"result %0d mismatch: expected %b got %b, bad fields %b ",
                                  "(stable_a b c, lamp_all_ok, lamp_a b c, report_due)"},
                                 result_no, want, out_word, diff);
                end
            end
        end
    end

    // Ends the run if neither channel moves a word for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("[debounced_level_monitor_unit] ERROR");
        $finish;
    end

endmodule
